// ----- rtl/ppr_pkg.sv -----
package ppr_pkg;

   localparam int CfgWidth  = 16;
   localparam int DurWidth  = 21;
   localparam int MagWidth  = DurWidth;
   localparam int CodeBits  = 12;
   localparam int CountWidth = 4;
   localparam int SerialBits = 10;
   localparam int ButtonBits = 2;
   localparam int CsrIndexWidth = 2;

   localparam logic [CfgWidth-1:0] ShortTimeReset = 16'd700;
   localparam logic [CfgWidth-1:0] LongTimeReset  = 16'd1400;
   localparam logic [CfgWidth-1:0] ToleranceReset = 16'd250;
   localparam logic [CountWidth-1:0] CodeBitsCount = 4'd12;
   localparam logic [CodeBits-1:0] ButtonMask = 12'h003;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SHORT_TIME = 2'd0,
      CSR_LONG_TIME  = 2'd1,
      CSR_TOLERANCE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CfgWidth-1:0] short_time;
      logic [CfgWidth-1:0] long_time;
      logic [CfgWidth-1:0] tolerance;
   } cfg_type;

   typedef struct packed {
      logic                  expect_gap;
      logic [MagWidth-2:0]   held_pulse;
      logic [CodeBits-1:0]   bit_shift;
      logic [CountWidth-1:0] bit_total;
      logic                  capture_over;
   } state_type;

   typedef struct packed {
      logic                emit;
      logic                found;
      logic [CodeBits-1:0] code_value;
   } result_type;

   // magnitude within target plus or minus tolerance, no overflow
   function automatic logic near_target(input logic [MagWidth-1:0] mag,
                                        input logic [CfgWidth-1:0] target,
                                        input logic [CfgWidth-1:0] tol);
      logic [MagWidth:0]   mag_plus_tol;
      logic [CfgWidth:0]   upper;
      logic                low_ok;
      logic                high_ok;
      mag_plus_tol = {1'b0, mag} + {{(MagWidth-CfgWidth+1){1'b0}}, tol};
      upper        = {1'b0, target} + {1'b0, tol};
      low_ok       = mag_plus_tol >= {{(MagWidth-CfgWidth+1){1'b0}}, target};
      high_ok      = mag <= {{(MagWidth-CfgWidth-1){1'b0}}, upper};
      return low_ok && high_ok;
   endfunction

endpackage

// ----- rtl/ppr_csr.sv -----
module ppr_csr
   import ppr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]      csr_write_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write onto its register, ignore unused indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SHORT_TIME: cfg_in.short_time = csr_write_data;
            CSR_LONG_TIME:  cfg_in.long_time  = csr_write_data;
            CSR_TOLERANCE:  cfg_in.tolerance  = csr_write_data;
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_time <= ShortTimeReset;
         cfg_ff.long_time  <= LongTimeReset;
         cfg_ff.tolerance  <= ToleranceReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ppr_step.sv -----
module ppr_step
   import ppr_pkg::*;
(
   input  cfg_type                     cfg,
   input  state_type                   state_cur,
   input  logic signed [DurWidth-1:0]  duration,
   input  logic                        first_sample,
   input  logic                        last_sample,
   output state_type                   state_next,
   output result_type                  result
);

   logic [MagWidth-1:0] gap_mag;
   logic [MagWidth-1:0] pulse_mag;
   logic                is_zero;
   logic                is_one;
   logic                done;
   state_type           s;

   // magnitude of the duration, most negative value fits unsigned
   assign gap_mag   = duration[DurWidth-1] ? (~duration + 1'b1) : duration;
   assign pulse_mag = {1'b0, state_cur.held_pulse};

   always_comb begin
      s      = state_cur;
      result = '0;
      done   = 1'b0;
      is_zero = 1'b0;
      is_one  = 1'b0;

      // open a new capture
      if (first_sample) begin
         s = '0;
      end

      if (!s.capture_over) begin
         if (!s.expect_gap) begin
            // pulse slot: negative skips on the first sample, else abandons
            if (duration[DurWidth-1]) begin
               if (!first_sample) begin
                  s.capture_over = 1'b1;
                  result.emit    = 1'b1;
                  done           = 1'b1;
               end
            end else begin
               s.held_pulse = duration[DurWidth-2:0];
               s.expect_gap = 1'b1;
            end
         end else begin
            // gap slot: classify the pair, a zero takes precedence over a one
            is_zero = near_target(pulse_mag, cfg.short_time, cfg.tolerance) &&
                      near_target(gap_mag, cfg.long_time, cfg.tolerance);
            is_one  = near_target(pulse_mag, cfg.long_time, cfg.tolerance) &&
                      near_target(gap_mag, cfg.short_time, cfg.tolerance);
            s.expect_gap = 1'b0;
            if (!is_zero && !is_one) begin
               s.bit_shift = '0;
               s.bit_total = '0;
            end else begin
               s.bit_shift = {s.bit_shift[CodeBits-2:0], ~is_zero};
               s.bit_total = s.bit_total + 1'b1;
               if (s.bit_total == CodeBitsCount) begin
                  s.capture_over    = 1'b1;
                  result.emit       = 1'b1;
                  result.found      = 1'b1;
                  result.code_value = s.bit_shift;
                  done              = 1'b1;
               end
            end
         end

         // capture end without a code
         if (!done && last_sample) begin
            s.capture_over = 1'b1;
            result.emit    = 1'b1;
         end
      end

      state_next = s;
   end

endmodule

// ----- rtl/pulse_pair_remote_code_decoder_core.sv -----
// Pulse-pair remote code decoder.
// Input channel (req_): one signed duration per transaction with first/last
// capture markers, accepted when req_valid is high and req_stall is low.
// Result channel (rsp_): at most one result per input transaction; found with
// the 12-bit code and its serial/button split, or a not-found marker with
// zero fields. A result is taken when rsp_valid is high and rsp_stall low.
// Configuration (csr_): short_time, long_time and tolerance, written at any
// edge with csr_write_enable high; change them only while the block is idle.
// Path: an accepted transaction is registered at the input, decoded once the
// result slot is free, and its result is registered in the result register
// that drives rsp_.
// Throughput: one transaction per cycle unless a result waits on rsp_stall; the
// decode is a handful of compares and a 12-bit shift between the input register
// and the result register. Stall: while a result waits on rsp_stall the input
// register holds its item and req_stall rises, so nothing is lost or repeated.
// Reset: synchronous; the registers return to 700/1400/250, the capture is
// closed and items are ignored until one carries first_sample.
module pulse_pair_remote_code_decoder_core
   import ppr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DurWidth-1:0]  req_duration,
   input  logic                        req_first_sample,
   input  logic                        req_last_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [CodeBits-1:0]         rsp_code_value,
   output logic [SerialBits-1:0]       rsp_serial_part,
   output logic [ButtonBits-1:0]       rsp_button_part,
   input  logic                        csr_write_enable,
   input  logic [CsrIndexWidth-1:0]    csr_index,
   input  logic [CfgWidth-1:0]         csr_write_data
);

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_step;
   result_type result;

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic signed [DurWidth-1:0] in_duration_ff;
   logic                       in_first_ff;
   logic                       in_last_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic                       out_found_ff;
   logic [CodeBits-1:0]        out_code_ff;
   logic                       accept;
   logic                       advance;

   ppr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ppr_step u_step (
      .cfg          (cfg),
      .state_cur    (state_ff),
      .duration     (in_duration_ff),
      .first_sample (in_first_ff),
      .last_sample  (in_last_ff),
      .state_next   (state_step),
      .result       (result)
   );

   // advance the held transaction once the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign state_in = advance ? state_step : state_ff;

   // load a new result or drop the one taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && result.emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{expect_gap: 1'b0, held_pulse: '0, bit_shift: '0,
                           bit_total: '0, capture_over: 1'b1};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_duration_ff <= req_duration;
         in_first_ff    <= req_first_sample;
         in_last_ff     <= req_last_sample;
      end
      if (advance && result.emit) begin
         out_found_ff <= result.found;
         out_code_ff  <= result.code_value;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_code_value  = out_code_ff;
   assign rsp_serial_part = out_code_ff[CodeBits-1:ButtonBits];
   assign rsp_button_part = out_code_ff[ButtonBits-1:0] & ButtonMask[ButtonBits-1:0];

endmodule

// ----- tb/pulse_pair_remote_code_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module pulse_pair_remote_code_decoder_core_tb
   import ppr_pkg::*;
();

   localparam int PhaseItems = 230;
   localparam int PhaseCount = 8;
   localparam int CycleLimit = 500000;
   localparam logic [CodeBits-1:0] DemoCode = 12'hA5C;

   typedef struct packed {
      logic                found;
      logic [CodeBits-1:0] code;
   } code_result_type;

   // Tracks the decoder state, predicts each result and checks what comes out
   class code_tracker_type;
      logic [CfgWidth-1:0] short_t = ShortTimeReset;
      logic [CfgWidth-1:0] long_t  = LongTimeReset;
      logic [CfgWidth-1:0] tol     = ToleranceReset;

      bit                         awaiting_gap = 1'b0;
      logic signed [DurWidth-1:0] held_pulse   = '0;
      logic [CodeBits-1:0]        code_bits    = '0;
      logic [CountWidth-1:0]      code_count   = '0;
      bit                         closed       = 1'b1;

      code_result_type expected_codes[$];
      int mismatch_count  = 0;
      int durations_taken = 0;
      int codes_seen      = 0;
      int misses_seen     = 0;

      function void set_register(csr_index_type idx, logic [CfgWidth-1:0] value);
         case (idx)
            CSR_SHORT_TIME: short_t = value;
            CSR_LONG_TIME:  long_t  = value;
            CSR_TOLERANCE:  tol     = value;
            default: ;
         endcase
      endfunction

      // magnitude within target plus or minus tolerance, in plain integers
      function bit near(logic signed [DurWidth-1:0] d, logic [CfgWidth-1:0] target);
         int mag;
         mag = (d < 0) ? -int'(d) : int'(d);
         return mag >= int'(target) - int'(tol) && mag <= int'(target) + int'(tol);
      endfunction

      function void close_capture(bit found, logic [CodeBits-1:0] code);
         code_result_type res;
         closed = 1'b1;
         res.found = found;
         res.code  = found ? code : '0;
         expected_codes.push_back(res);
      endfunction

      // Advance the decode by one accepted duration
      function void accept_duration(logic signed [DurWidth-1:0] d, bit first, bit last);
         int decoded;
         durations_taken++;
         if (first) begin
            awaiting_gap = 1'b0;
            held_pulse   = '0;
            code_bits    = '0;
            code_count   = '0;
            closed       = 1'b0;
         end
         if (closed) return;
         if (!awaiting_gap) begin
            if (d < 0) begin
               // negative pulse: skipped when opening, else the capture is abandoned
               if (!first) begin
                  close_capture(1'b0, '0);
                  return;
               end
            end else begin
               held_pulse   = d;
               awaiting_gap = 1'b1;
            end
         end else begin
            awaiting_gap = 1'b0;
            if (near(held_pulse, short_t) && near(d, long_t))
               decoded = 0;
            else if (near(held_pulse, long_t) && near(d, short_t))
               decoded = 1;
            else
               decoded = -1;
            if (decoded < 0) begin
               code_bits  = '0;
               code_count = '0;
            end else begin
               code_bits  = {code_bits[CodeBits-2:0], decoded[0]};
               code_count = code_count + 1'b1;
               if (code_count == CodeBitsCount) begin
                  close_capture(1'b1, code_bits);
                  return;
               end
            end
         end
         if (last) close_capture(1'b0, '0);
      endfunction

      task report_mismatch(string what, int got, int want);
         mismatch_count++;
         if (mismatch_count <= 20)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
      endtask

      // Compare one result transaction with the oldest prediction
      task check_code(logic found, logic [CodeBits-1:0] code,
                      logic [SerialBits-1:0] serial, logic [ButtonBits-1:0] button);
         code_result_type want;
         if (expected_codes.size() == 0) begin
            report_mismatch("result with nothing pending", found, 0);
            return;
         end
         want = expected_codes.pop_front();
         if (found !== want.found) report_mismatch("found", found, want.found);
         if (code !== want.code) report_mismatch("code_value", code, want.code);
         if (serial !== want.code[CodeBits-1:ButtonBits])
            report_mismatch("serial_part", serial, want.code[CodeBits-1:ButtonBits]);
         if (button !== want.code[ButtonBits-1:0])
            report_mismatch("button_part", button, want.code[ButtonBits-1:0]);
         if (want.found) codes_seen++;
         else misses_seen++;
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [DurWidth-1:0] req_duration;
   logic                       req_first_sample;
   logic                       req_last_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_found;
   logic [CodeBits-1:0]        rsp_code_value;
   logic [SerialBits-1:0]      rsp_serial_part;
   logic [ButtonBits-1:0]      rsp_button_part;
   logic                       csr_write_enable;
   logic [CsrIndexWidth-1:0]   csr_index;
   logic [CfgWidth-1:0]        csr_write_data;

   code_tracker_type tracker;
   bit quiet = 1'b0;
   bit opening = 1'b0;
   int items_sent = 0;
   int settings_used = 1;
   int cycle_count = 0;

   pulse_pair_remote_code_decoder_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_duration     (req_duration),
      .req_first_sample (req_first_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_code_value   (rsp_code_value),
      .rsp_serial_part  (rsp_serial_part),
      .rsp_button_part  (rsp_button_part),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_code(rsp_found, rsp_code_value, rsp_serial_part, rsp_button_part);
         if (req_valid && !req_stall)
            tracker.accept_duration(req_duration, req_first_sample, req_last_sample);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, tracker.expected_codes.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int draw_wait();
      if (quiet) return 0;
      return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 14)) : 0;
   endfunction

   function automatic int random_duration();
      case ($urandom_range(0, 15))
         0:       return -(1 << (DurWidth - 1));
         1:       return (1 << (DurWidth - 1)) - 1;
         2:       return 0;
         default: return int'($urandom_range(0, (1 << DurWidth) - 1));
      endcase
   endfunction

   // A length that matches the target, with the odd miss just outside the window
   function automatic int pick_near(logic [CfgWidth-1:0] target, bit sloppy);
      int lo;
      int hi;
      lo = int'(target) - int'(tracker.tol);
      if (lo < 0) lo = 0;
      hi = int'(target) + int'(tracker.tol);
      if (sloppy && $urandom_range(0, 15) == 0)
         return ($urandom_range(0, 1) == 1 || lo == 0) ? hi + 1 : lo - 1;
      case ($urandom_range(0, 7))
         0:       return lo;
         1:       return hi;
         default: return int'($urandom_range(hi, lo));
      endcase
   endfunction

   // Stall the result channel for a random spell before each transaction
   initial begin : result_stall
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Present one duration and hold it until the block takes it
   task automatic send_item(int dur, bit first, bit last);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_duration     <= DurWidth'(dur);
      req_first_sample <= first;
      req_last_sample  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // The first item of a capture carries the opening marker
   task automatic send_capture_item(int d, bit last);
      send_item(d, opening, last);
      opening = 1'b0;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.expected_codes.size() != 0) @(negedge clock);
   endtask

   // Reprogram the timing registers once the block has gone quiet
   task automatic load_timing(logic [CfgWidth-1:0] s, logic [CfgWidth-1:0] l,
                              logic [CfgWidth-1:0] w);
      csr_index_type order[3] = '{CSR_SHORT_TIME, CSR_LONG_TIME, CSR_TOLERANCE};
      logic [CfgWidth-1:0] vals[3];
      vals = '{s, l, w};
      drain_results();
      repeat (4) @(negedge clock);
      for (int i = 0; i < 3; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= order[i];
         csr_write_data   <= vals[i];
         @(negedge clock);
         tracker.set_register(order[i], vals[i]);
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // One capture: mostly a clean 12-bit code, sometimes cut short, abandoned,
   // restarted by the next capture or preceded by a garbage pair
   task automatic send_frame();
      logic [CodeBits-1:0] word;
      int style;
      int nbits;
      int cut;
      int pulse_len;
      int gap_len;
      bit sloppy;
      bit bit_val;
      bit mark_last_gap;
      word   = CodeBits'($urandom);
      style  = $urandom_range(0, 11);
      sloppy = ($urandom_range(0, 3) == 0);
      nbits  = (style == 8 || style == 9) ? $urandom_range(0, CodeBits - 1) : CodeBits;
      cut    = (style == 10) ? $urandom_range(0, CodeBits - 1) : CodeBits;
      mark_last_gap = style < 9 && nbits > 0 && $urandom_range(0, 1) == 1;
      opening = 1'b1;
      if ($urandom_range(0, 2) == 0)
         send_capture_item(-int'($urandom_range(0, 3000)), 1'b0);
      if (style == 11) begin
         send_capture_item(random_duration(), 1'b0);
         send_capture_item(random_duration(), 1'b0);
      end
      for (int k = 0; k < nbits; k++) begin
         bit_val   = word[CodeBits-1-k];
         pulse_len = pick_near(bit_val ? tracker.long_t : tracker.short_t, sloppy);
         gap_len   = pick_near(bit_val ? tracker.short_t : tracker.long_t, sloppy);
         if (k == cut) begin
            send_capture_item(-1 - int'($urandom_range(0, 2000)), 1'b0);
            break;
         end
         send_capture_item(pulse_len, 1'b0);
         if ($urandom_range(0, 3) != 0) gap_len = -gap_len;
         send_capture_item(gap_len, mark_last_gap && k == nbits - 1);
      end
      // close the capture unless it is left open for the next one to restart
      if (style == 10) begin
         if ($urandom_range(0, 1) == 1) send_capture_item(random_duration(), 1'b1);
      end else if (style != 9 && !mark_last_gap) begin
         if (nbits == CodeBits && $urandom_range(0, 1) == 1)
            send_capture_item(random_duration(), 1'b0);
         send_capture_item($urandom_range(0, 1) == 1 ? random_duration()
                           : pick_near(tracker.short_t, 1'b0), 1'b1);
      end
   endtask

   initial begin
      int pulse_len;
      int gap_len;
      tracker          = new;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_duration     = '0;
      req_first_sample = 1'b0;
      req_last_sample  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SHORT_TIME;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // item before any capture is opened: ignored
      send_item(0, 1'b0, 1'b0);
      // negative opening level then end: not-found
      send_item(-(1 << (DurWidth - 1)), 1'b1, 1'b1);
      // lone pulse at the end: not-found
      send_item((1 << (DurWidth - 1)) - 1, 1'b1, 1'b1);
      // one bit on a negative gap, then a negative pulse abandons
      send_item(700, 1'b1, 1'b0);
      send_item(-1400, 1'b0, 1'b0);
      send_item(-1, 1'b0, 1'b0);
      // full code at the window edges, opened by a skipped negative level
      send_item(-300, 1'b1, 1'b0);
      for (int k = 0; k < CodeBits; k++) begin
         if (DemoCode[CodeBits-1-k]) begin
            pulse_len = k[0] ? 1150 : 1650;
            gap_len   = k[0] ? 950 : 450;
         end else begin
            pulse_len = k[0] ? 450 : 950;
            gap_len   = k[0] ? 1650 : 1150;
         end
         send_item(pulse_len, 1'b0, 1'b0);
         send_item((k == 5) ? gap_len : -gap_len, 1'b0, k == CodeBits - 1);
      end

      // random captures across several timing settings
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: ;
            1: load_timing(16'd0, 16'd65535, 16'd0);
            2: load_timing(16'd65535, 16'd0, 16'd65535);
            3: load_timing(16'd300, 16'd600, 16'd100);
            5: load_timing(16'd65535, 16'd65535, 16'd0);
            7: load_timing(ShortTimeReset, LongTimeReset, ToleranceReset);
            default: load_timing(CfgWidth'($urandom_range(100, 5000)),
                                 CfgWidth'($urandom_range(100, 9000)),
                                 CfgWidth'($urandom_range(0, 1000)));
         endcase
         while (items_sent < (p + 1) * PhaseItems) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_item(random_duration(), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 3) == 0);
            end else begin
               send_frame();
            end
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end

      drain_results();
      repeat (8) @(negedge clock);
      $display("covered %0d durations under %0d timing settings", tracker.durations_taken,
               settings_used);
      $display("checked %0d decoded codes and %0d not-found results, %0d mismatches",
               tracker.codes_seen, tracker.misses_seen, tracker.mismatch_count);
      if (tracker.mismatch_count == 0 && tracker.expected_codes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ppr_pkg.sv
rtl/ppr_csr.sv
rtl/ppr_step.sv
rtl/pulse_pair_remote_code_decoder_core.sv
tb/pulse_pair_remote_code_decoder_core_tb.sv
